// File: hdl/tlik_pkg.sv
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared constants, stage types and the arctangent table for the two-link
// inverse kinematics pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package tlik_pkg;

  localparam int DIV_STEPS         = 17;
  localparam int SQRT_STEPS        = 17;
  localparam int CORDIC_STAGES_DEF = 18;

  localparam logic [14:0]        ARM_LEN_RST = 15'd3200;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [26:0]        TICK_GAIN   = 27'd66754421;
  localparam logic signed [47:0] TICK_BIAS   = 48'sd6012954214400;
  localparam logic signed [47:0] TRUNC_ADJ   = 48'sd4294967295;

  // restoring divider step: rem < 2*den, quotient shifts in from the right
  typedef struct packed {
    logic        vld;
    logic [31:0] rem;
    logic [30:0] den;
    logic [16:0] quo;
    logic        neg;
    logic        oor;
  } div_t;

  // bitwise integer square root step
  typedef struct packed {
    logic               vld;
    logic [32:0]        a;
    logic [32:0]        r;
    logic signed [17:0] c;
    logic               oor;
  } sqrt_t;

  // vectoring rotation step
  typedef struct packed {
    logic               vld;
    logic signed [33:0] u;
    logic signed [33:0] v;
    logic signed [19:0] z;
    logic               vzero;
    logic               upos;
    logic               tag;
  } cordic_t;

  // atan(2^-i) in Q16, rounded
  function automatic logic signed [19:0] atan_entry(input int idx);
    logic signed [19:0] e;
    case (idx)
      0:       e = 20'sd51472;
      1:       e = 20'sd30385;
      2:       e = 20'sd16055;
      3:       e = 20'sd8150;
      4:       e = 20'sd4091;
      5:       e = 20'sd2047;
      6:       e = 20'sd1024;
      7:       e = 20'sd512;
      8:       e = 20'sd256;
      9:       e = 20'sd128;
      10:      e = 20'sd64;
      11:      e = 20'sd32;
      12:      e = 20'sd16;
      13:      e = 20'sd8;
      14:      e = 20'sd4;
      15:      e = 20'sd2;
      16:      e = 20'sd1;
      default: e = 20'sd0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

// File: hdl/tlik_div_cell.sv
// ----------------------------------------------------------------------------
// tlik_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module tlik_div_cell import tlik_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire div_t d_in,
  output div_t      d_out
);

  div_t        q_r;
  logic        ge;
  logic [31:0] sel;

  always_comb begin
    ge  = d_in.rem >= {1'b0, d_in.den};
    sel = ge ? (d_in.rem - {1'b0, d_in.den}) : d_in.rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= d_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r.rem <= {sel[30:0], 1'b0};
      q_r.den <= d_in.den;
      q_r.quo <= {d_in.quo[15:0], ge};
      q_r.neg <= d_in.neg;
      q_r.oor <= d_in.oor;
    end
  end

  assign d_out = q_r;

endmodule
`default_nettype wire

// File: hdl/tlik_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tlik_sqrt_cell
// One step of the bitwise integer square root; BIT_POS is the trial bit.
// ----------------------------------------------------------------------------
`default_nettype none
module tlik_sqrt_cell import tlik_pkg::*; #(
  parameter int BIT_POS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire sqrt_t s_in,
  output sqrt_t      s_out
);

  localparam logic [33:0] TRIAL = 34'd1 << BIT_POS;

  sqrt_t       q_r;
  logic [33:0] t;
  logic        ge;

  always_comb begin
    t  = {1'b0, s_in.r} + TRIAL;
    ge = {1'b0, s_in.a} >= t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= s_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r.a   <= ge ? (s_in.a - t[32:0]) : s_in.a;
      q_r.r   <= ge ? ((s_in.r >> 1) + TRIAL[32:0]) : (s_in.r >> 1);
      q_r.c   <= s_in.c;
      q_r.oor <= s_in.oor;
    end
  end

  assign s_out = q_r;

endmodule
`default_nettype wire

// File: hdl/tlik_cordic_cell.sv
// ----------------------------------------------------------------------------
// tlik_cordic_cell
// One vectoring CORDIC rotation by atan(2^-IDX).
// ----------------------------------------------------------------------------
`default_nettype none
module tlik_cordic_cell import tlik_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire cordic_t c_in,
  output cordic_t      c_out
);

  localparam logic signed [19:0] ANG = atan_entry(IDX);

  cordic_t            q_r;
  logic signed [33:0] du;
  logic signed [33:0] dv;

  always_comb begin
    du = c_in.v >>> IDX;
    dv = c_in.u >>> IDX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (en) begin
      q_r.vld <= c_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!c_in.v[33]) begin
        q_r.u <= c_in.u + du;
        q_r.v <= c_in.v - dv;
        q_r.z <= c_in.z + ANG;
      end else begin
        q_r.u <= c_in.u - du;
        q_r.v <= c_in.v + dv;
        q_r.z <= c_in.z - ANG;
      end
      q_r.vzero <= c_in.vzero;
      q_r.upos  <= c_in.upos;
      q_r.tag   <= c_in.tag;
    end
  end

  assign c_out = q_r;

endmodule
`default_nettype wire

// File: hdl/tlik_atan2.sv
// ----------------------------------------------------------------------------
// tlik_atan2
// Pipelined atan2(v, u) in Q3.16: quadrant fold, CORDIC cell chain, clamp.
// ----------------------------------------------------------------------------
`default_nettype none
module tlik_atan2 import tlik_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire logic signed [17:0] in_v,
  input  wire logic signed [17:0] in_u,
  input  wire logic               in_tag,
  output logic                    out_vld,
  output logic signed [19:0]      out_z,
  output logic                    out_tag
);

  localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  cordic_t            chain [N+1];
  cordic_t            pre_r;
  logic signed [33:0] us;
  logic signed [33:0] vs;
  logic signed [19:0] zc;
  logic               vld_r;
  logic signed [19:0] z_r;
  logic               tag_r;

  always_comb begin
    us = {{2{in_u[17]}}, in_u, 14'b0};
    vs = {{2{in_v[17]}}, in_v, 14'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r.vld <= 1'b0;
    end else if (en) begin
      pre_r.vld <= in_vld;
    end
  end

  // fold the left half-plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_u[17] && !in_v[17] && (in_v != 18'sd0)) begin
        pre_r.u <= vs;
        pre_r.v <= -us;
        pre_r.z <= HALF_PI_Q16;
      end else if (in_u[17]) begin
        pre_r.u <= -vs;
        pre_r.v <= us;
        pre_r.z <= -HALF_PI_Q16;
      end else begin
        pre_r.u <= us;
        pre_r.v <= vs;
        pre_r.z <= 20'sd0;
      end
      pre_r.vzero <= (in_v == 18'sd0);
      pre_r.upos  <= !in_u[17] && (in_u != 18'sd0);
      pre_r.tag   <= in_tag;
    end
  end

  assign chain[0] = pre_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    tlik_cordic_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .c_in  (chain[i]),
      .c_out (chain[i+1])
    );
  end

  always_comb begin
    zc = chain[N].z;
    if (zc > PI_Q16) begin
      zc = PI_Q16;
    end else if (zc < -PI_Q16) begin
      zc = -PI_Q16;
    end
    if (chain[N].vzero) begin
      zc = chain[N].upos ? 20'sd0 : PI_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= chain[N].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r   <= zc;
      tag_r <= chain[N].tag;
    end
  end

  assign out_vld = vld_r;
  assign out_z   = z_r;
  assign out_tag = tag_r;

endmodule
`default_nettype wire

// File: hdl/two_link_ik_to_servo_ticks_core.sv
// Throughput: one transfer per cycle; the stages include the registers of the cell chains
// (17 divider cells, 17 square-root cells, two CORDIC chains in lockstep).
// The pipeline holds only while a result sits unaccepted at the output.
// Reset: synchronous, active low; clears all valid flags and sets arm_length to 3200.
// ----------------------------------------------------------------------------
// two_link_ik_to_servo_ticks_core
// Two-link planar arm inverse kinematics to servo timer ticks.
// ----------------------------------------------------------------------------
`default_nettype none
module two_link_ik_to_servo_ticks_core import tlik_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [14:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_target_x,
  input  wire logic signed [15:0] in_target_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [13:0]      out_shoulder_ticks,
  output logic [12:0]             out_elbow_ticks,
  output logic                    out_out_of_reach
);

  // x,y wait alongside the divider and square-root chains
  localparam int DLY = 3 + DIV_STEPS + SQRT_STEPS;

  logic en;

  logic [14:0] arm_length_r;

  logic               p0_vld_r;
  logic signed [15:0] p0_x_r;
  logic signed [15:0] p0_y_r;
  logic [30:0]        p0_xx_r;
  logic [30:0]        p0_yy_r;
  logic [30:0]        p0_den_r;
  logic               p0_lenz_r;
  logic signed [31:0] xx_full;
  logic signed [31:0] yy_full;
  logic [29:0]        ll;

  logic [31:0]        r2;
  logic signed [32:0] num;
  logic signed [32:0] num_mag;
  div_t               p1_r;
  div_t               dchain [DIV_STEPS+1];

  logic               pc_vld_r;
  logic signed [17:0] pc_c_r;
  logic               pc_oor_r;
  logic signed [17:0] c_sel;
  logic signed [35:0] csq;
  sqrt_t              pa_r;
  sqrt_t              schain [SQRT_STEPS+1];

  logic signed [15:0] dx_r [DLY];
  logic signed [15:0] dy_r [DLY];

  logic               a1_vld;
  logic signed [19:0] a1_z;
  logic               a1_tag;
  logic               a2_vld;
  logic signed [19:0] a2_z;
  logic               a2_oor;

  logic               q_vld_r;
  logic signed [19:0] q1_r;
  logic signed [19:0] q2_r;
  logic               q_oor_r;
  logic signed [19:0] q2c;

  logic               m_vld_r;
  logic signed [47:0] m1_r;
  logic signed [47:0] m2_r;
  logic               m_oor_r;
  logic signed [47:0] t1;
  logic signed [47:0] t2;

  logic               out_valid_r;
  logic signed [13:0] sh_r;
  logic [12:0]        el_r;
  logic               oor_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_length_r <= ARM_LEN_RST;
    end else if (cfg_we) begin
      arm_length_r <= cfg_wdata;
    end
  end

  // squares and link term
  always_comb begin
    xx_full = in_target_x * in_target_x;
    yy_full = in_target_y * in_target_y;
    ll      = arm_length_r * arm_length_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
      p1_r.vld <= 1'b0;
      pc_vld_r <= 1'b0;
      pa_r.vld <= 1'b0;
      q_vld_r  <= 1'b0;
      m_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p0_vld_r <= in_valid;
      p1_r.vld <= p0_vld_r;
      pc_vld_r <= dchain[DIV_STEPS].vld;
      pa_r.vld <= pc_vld_r;
      q_vld_r  <= a2_vld;
      m_vld_r  <= q_vld_r;
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_x_r    <= in_target_x;
      p0_y_r    <= in_target_y;
      p0_xx_r   <= xx_full[30:0];
      p0_yy_r   <= yy_full[30:0];
      p0_den_r  <= {ll, 1'b0};
      p0_lenz_r <= (arm_length_r == 15'd0);
    end
  end

  // numerator sign, magnitude and reach test
  always_comb begin
    r2      = {1'b0, p0_xx_r} + {1'b0, p0_yy_r};
    num     = $signed({1'b0, r2}) - $signed({2'b0, p0_den_r});
    num_mag = num[32] ? -num : num;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r.rem <= {1'b0, num_mag[30:0]};
      p1_r.den <= p0_den_r;
      p1_r.quo <= 17'd0;
      p1_r.neg <= num[32];
      p1_r.oor <= p0_lenz_r || (num > $signed({2'b0, p0_den_r}));
    end
  end

  assign dchain[0] = p1_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    tlik_div_cell u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (dchain[i]),
      .d_out (dchain[i+1])
    );
  end

  always_comb begin
    if (dchain[DIV_STEPS].oor) begin
      c_sel = 18'sd65536;
    end else if (dchain[DIV_STEPS].neg) begin
      c_sel = -$signed({1'b0, dchain[DIV_STEPS].quo});
    end else begin
      c_sel = $signed({1'b0, dchain[DIV_STEPS].quo});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_c_r   <= c_sel;
      pc_oor_r <= dchain[DIV_STEPS].oor;
    end
  end

  assign csq = pc_c_r * pc_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r.a   <= 33'h1_0000_0000 - csq[32:0];
      pa_r.r   <= 33'd0;
      pa_r.c   <= pc_c_r;
      pa_r.oor <= pc_oor_r;
    end
  end

  assign schain[0] = pa_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    tlik_sqrt_cell #(.BIT_POS(2 * (SQRT_STEPS - 1 - k))) u_sqrt (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .s_in  (schain[k]),
      .s_out (schain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0] <= p0_x_r;
      dy_r[0] <= p0_y_r;
      for (int j = 1; j < DLY; j++) begin
        dx_r[j] <= dx_r[j-1];
        dy_r[j] <= dy_r[j-1];
      end
    end
  end

  tlik_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan_sh (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (schain[SQRT_STEPS].vld),
    .in_v    ({{2{dx_r[DLY-1][15]}}, dx_r[DLY-1]}),
    .in_u    (-{{2{dy_r[DLY-1][15]}}, dy_r[DLY-1]}),
    .in_tag  (1'b0),
    .out_vld (a1_vld),
    .out_z   (a1_z),
    .out_tag (a1_tag)
  );

  tlik_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan_el (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (schain[SQRT_STEPS].vld),
    .in_v    ({1'b0, schain[SQRT_STEPS].r[16:0]}),
    .in_u    (-schain[SQRT_STEPS].c),
    .in_tag  (schain[SQRT_STEPS].oor),
    .out_vld (a2_vld),
    .out_z   (a2_z),
    .out_tag (a2_oor)
  );

  always_comb begin
    q2c = a2_z[19] ? 20'sd0 : a2_z;
  end

  // shoulder angle less half the elbow angle
  always_ff @(posedge clk) begin
    if (en) begin
      q2_r    <= q2c;
      q1_r    <= a1_z - (q2c >>> 1) + {19'b0, a1_tag & a1_vld & 1'b0};
      q_oor_r <= a2_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= q1_r * $signed({1'b0, TICK_GAIN}) + TICK_BIAS;
      m2_r    <= q2_r * $signed({1'b0, TICK_GAIN}) + TICK_BIAS;
      m_oor_r <= q_oor_r;
    end
  end

  // truncate toward zero
  always_comb begin
    t1 = m1_r[47] ? ((m1_r + TRUNC_ADJ) >>> 32) : (m1_r >>> 32);
    t2 = m2_r[47] ? ((m2_r + TRUNC_ADJ) >>> 32) : (m2_r >>> 32);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r  <= t1[13:0];
      el_r  <= t2[12:0];
      oor_r <= m_oor_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_shoulder_ticks = sh_r;
  assign out_elbow_ticks    = el_r;
  assign out_out_of_reach   = oor_r;

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives target points through the two-link arm inverse kinematics core,
// predicts the servo ticks per point in a scoreboard, and compares every
// result in order. Link length is rewritten between phases while idle.
// ----------------------------------------------------------------------------
`default_nettype none

class ik_scoreboard;
  typedef struct {
    logic signed [13:0] shoulder;
    logic [12:0]        elbow;
    logic               oor;
  } ticks_t;

  ticks_t      pending[$];
  logic [14:0] link_len;
  int          errors;

  function new();
    link_len = tlik_pkg::ARM_LEN_RST;
    errors   = 0;
  endfunction

  static function longint shr_floor(longint v, int n);
    if (v >= 0) return v >>> n;
    return -(((-v) - 1) >>> n) - 1;
  endfunction

  static function longint int_sqrt(longint a);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > a) b = b >>> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  static function longint arctan2(longint v, longint u);
    longint z, t, du, dv, tab;
    z = 0;
    if (v == 0) return (u > 0) ? 0 : longint'(tlik_pkg::PI_Q16);
    u = u * 16384;
    v = v * 16384;
    if (u < 0) begin
      if (v > 0) begin
        t = u; u = v; v = -t; z = tlik_pkg::HALF_PI_Q16;
      end else begin
        t = u; u = -v; v = t; z = -longint'(tlik_pkg::HALF_PI_Q16);
      end
    end
    for (int i = 0; i < tlik_pkg::CORDIC_STAGES_DEF; i++) begin
      du  = shr_floor(v, i);
      dv  = shr_floor(u, i);
      tab = longint'(tlik_pkg::atan_entry(i));
      if (v >= 0) begin
        u = u + du; v = v - dv; z = z + tab;
      end else begin
        u = u - du; v = v + dv; z = z - tab;
      end
    end
    if (z > tlik_pkg::PI_Q16) z = tlik_pkg::PI_Q16;
    if (z < -longint'(tlik_pkg::PI_Q16)) z = -longint'(tlik_pkg::PI_Q16);
    return z;
  endfunction

  static function longint angle_to_ticks(longint q);
    longint acc;
    acc = q * longint'(tlik_pkg::TICK_GAIN) + longint'(tlik_pkg::TICK_BIAS);
    return acc / (64'sd1 <<< 32);  // truncate toward zero
  endfunction

  function void note_target(logic signed [15:0] tx, logic signed [15:0] ty);
    longint x, y, len, r2, den, num, c, s, q1, q2;
    ticks_t e;
    x   = tx;
    y   = ty;
    len = link_len;
    r2  = x * x + y * y;
    den = 2 * len * len;
    num = r2 - den;
    e.oor = 1'b0;
    if (len == 0 || num > den) begin
      c = 65536;
      e.oor = 1'b1;
    end else begin
      c = (num * 65536) / den;
    end
    s  = int_sqrt((64'sd1 <<< 32) - c * c);
    q2 = arctan2(s, -c);
    if (q2 < 0) q2 = 0;
    if (q2 > tlik_pkg::PI_Q16) q2 = tlik_pkg::PI_Q16;
    q1 = arctan2(x, -y) - shr_floor(q2, 1);
    e.shoulder = 14'(angle_to_ticks(q1));
    e.elbow    = 13'(angle_to_ticks(q2));
    pending.push_back(e);
  endfunction

  function void report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endfunction

  function void check_result(logic signed [13:0] sh, logic [12:0] el, logic oor);
    ticks_t e;
    if (pending.size() == 0) begin
      report("unexpected result", sh, 0);
      return;
    end
    e = pending.pop_front();
    if (sh !== e.shoulder) report("shoulder_ticks", sh, e.shoulder);
    if (el !== e.elbow) report("elbow_ticks", el, e.elbow);
    if (oor !== e.oor) report("out_of_reach", oor, e.oor);
  endfunction
endclass

module tb_top;
  import tlik_pkg::*;

  localparam int LATENCY   = 43 + CORDIC_STAGES_DEF;
  localparam int WATCH_MAX = 20000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [14:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_target_x;
  logic signed [15:0] in_target_y;
  logic               out_valid;
  logic               out_stall;
  logic signed [13:0] out_shoulder_ticks;
  logic [12:0]        out_elbow_ticks;
  logic               out_out_of_reach;

  ik_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;

  two_link_ik_to_servo_ticks_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_shoulder_ticks(out_shoulder_ticks), .out_elbow_ticks(out_elbow_ticks),
    .out_out_of_reach(out_out_of_reach)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // note inputs and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid && !in_stall) begin
        sb.note_target(in_target_x, in_target_y);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_shoulder_ticks, out_elbow_ticks, out_out_of_reach);
      end
      if (quiet_cycles >= WATCH_MAX) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // receiver stall, drawn at each falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // leaves valid high after the transfer; the next call or drain drops it
  task automatic send_target(logic signed [15:0] tx, logic signed [15:0] ty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_target_x <= tx;
    in_target_y <= ty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_link(logic [14:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.link_len = len;
  endtask

  // mostly reachable points, sometimes anything in range
  task automatic send_random(int n);
    int lim;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        send_target(16'($urandom), 16'($urandom));
      end else begin
        lim = 2 * int'(sb.link_len) + 8;
        if (lim > 32767) lim = 32767;
        send_target(16'($urandom_range(2 * lim) - lim), 16'($urandom_range(2 * lim) - lim));
      end
    end
  endtask

  initial begin
    logic [14:0] lens[6];
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_target_x = '0;
    in_target_y = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners at the reset length
    send_target(16'sd0, 16'sd0);
    send_target(16'sd32767, 16'sd32767);
    send_target(-16'sd32768, -16'sd32768);
    send_target(16'sd32767, -16'sd32768);
    send_target(-16'sd32768, 16'sd32767);
    send_target(16'sd6400, 16'sd0);
    send_target(16'sd6401, 16'sd0);
    send_target(16'sd0, -16'sd6400);
    send_target(-16'sd3200, 16'sd0);
    send_target(16'sd3200, 16'sd0);
    send_target(16'sd0, 16'sd3200);
    send_target(16'sd0, -16'sd1);
    send_target(16'sd1, 16'sd0);
    send_target(-16'sd1, 16'sd0);
    send_target(16'sd100, -16'sd4000);
    send_target(-16'sd2500, -16'sd2500);
    drain();
    write_link(15'd0);
    send_target(16'sd0, 16'sd0);
    send_target(16'sd5, -16'sd7);
    drain();
    write_link(15'd32767);
    send_target(-16'sd32768, 16'sd0);
    send_target(16'sd1, 16'sd1);
    drain();

    lens = '{15'd3200, 15'd1, 15'd32767, 15'd800, 15'd12000, 15'd0};
    for (int p = 0; p < 6; p++) begin
      write_link(p == 5 ? 15'($urandom_range(32767)) : lens[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      send_random(250);
      drain();
    end
    recv_stall_pct = 0;
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
